>>> design/art_pkg.sv
package art_pkg;

   // Table geometry.
   localparam int NUM_SLOTS  = 16;
   localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W      = $clog2(NUM_SLOTS + 1);

   // Field widths and fixed constants.
   localparam int SRC_W        = 3;
   localparam int DATA_W       = 32;
   localparam int SLOT_OUT_W   = 4;
   localparam int SOURCE_SHIFT = 24;
   localparam logic [DATA_W-1:0] WINDOW_RESET = 32'd60000;

   // One table entry as stored in the slot memory.
   typedef struct packed {
      logic [SRC_W-1:0]  source;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] stamp;
      logic [DATA_W-1:0] count;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // Control from the sequencer to the datapath.
   typedef struct packed {
      logic             load;
      logic             cmp_vld;
      logic             cmp_valid;
      logic             update;
      logic             upd_hit;
      logic [IDX_W-1:0] upd_slot;
      logic             upd_evict;
   } seq_ctl_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic match;
      logic out_busy;
   } dp_stat_type;

endpackage

>>> design/art_if.sv
// Request channel: one alert event per transfer.
interface art_req_if import art_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SRC_W-1:0]  src_num;
   logic [DATA_W-1:0] text_hash;
   logic [DATA_W-1:0] now_ms;

   modport source (output valid, output src_num, output text_hash, output now_ms,
                   input ready);
   modport sink   (input valid, input src_num, input text_hash, input now_ms,
                   output ready);
endinterface

// Response channel: one verdict per event.
interface art_rsp_if import art_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  emit;
   logic [DATA_W-1:0]     dropped_count;
   logic [SLOT_OUT_W-1:0] slot_used;
   logic                  evicted;

   modport source (output valid, output emit, output dropped_count, output slot_used,
                   output evicted, input ready);
   modport sink   (input valid, input emit, input dropped_count, input slot_used,
                   input evicted, output ready);
endinterface

>>> design/art_ram.sv
module art_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, single registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/art_seq.sv
module art_seq import art_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dp_stat_type       stat,
   output seq_ctl_type       ctl,
   output logic              rd_en,
   output logic [IDX_W-1:0]  rd_addr
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;

   logic             cmp_active;
   logic             cur_valid;
   logic             hit_now;
   logic             last_cmp;
   logic             upd_fire;
   logic [IDX_W-1:0] upd_slot;

   // Compare stage: the entry read in the previous cycle is checked now.
   assign cmp_active = (state_ff == ST_SCAN) && cmp_vld_ff;
   assign cur_valid  = valid_ff[cmp_idx_ff];
   assign hit_now    = cmp_active && cur_valid && stat.match;
   assign last_cmp   = cmp_idx_ff == IDX_W'(NUM_SLOTS - 1);
   assign upd_fire   = (state_ff == ST_UPDATE) && !stat.out_busy;

   // Slot written by the update: the hit, else the lowest free slot, else slot 0.
   always_comb begin
      priority if (hit_ff) begin
         upd_slot = hit_idx_ff;
      end else if (free_found_ff) begin
         upd_slot = free_idx_ff;
      end else begin
         upd_slot = '0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (cmp_active && (hit_now || last_cmp)) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!stat.out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_ready     = state_ff == ST_IDLE;
      rd_en         = (state_ff == ST_SCAN) && (scan_ff < CNT_W'(NUM_SLOTS));
      rd_addr       = scan_ff[IDX_W-1:0];
      ctl.load      = (state_ff == ST_IDLE) && req_valid;
      ctl.cmp_vld   = cmp_active;
      ctl.cmp_valid = cur_valid;
      ctl.update    = upd_fire;
      ctl.upd_hit   = hit_ff;
      ctl.upd_slot  = upd_slot;
      ctl.upd_evict = !hit_ff && !free_found_ff;
   end

   // Scan counters, hit and free tracking, valid bits.
   always_comb begin
      scan_in       = scan_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      if (ctl.load) begin
         scan_in       = '0;
         hit_in        = 1'b0;
         free_found_in = 1'b0;
      end
      if (rd_en) begin
         scan_in    = scan_ff + CNT_W'(1);
         cmp_vld_in = 1'b1;
         cmp_idx_in = rd_addr;
      end
      if (hit_now) begin
         hit_in     = 1'b1;
         hit_idx_in = cmp_idx_ff;
      end else if (cmp_active && !cur_valid && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = cmp_idx_ff;
      end
      if (upd_fire && !hit_ff) begin
         valid_in[upd_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
   end

endmodule

>>> design/art_datapath.sv
module art_datapath import art_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [DATA_W-1:0] csr_wr_data,
   input  logic [SRC_W-1:0]  req_src_num,
   input  logic [DATA_W-1:0] req_text_hash,
   input  logic [DATA_W-1:0] req_now_ms,
   input  seq_ctl_type       ctl,
   output dp_stat_type       stat,
   input  slot_entry_type    rd_entry,
   output slot_entry_type    wr_entry,
   art_rsp_if.source         rsp
);

   logic [DATA_W-1:0]     window_ff, window_in;
   logic [SRC_W-1:0]      src_ff, src_in;
   logic [DATA_W-1:0]     key_ff, key_in;
   logic [DATA_W-1:0]     now_ff, now_in;
   logic [DATA_W-1:0]     hit_stamp_ff, hit_stamp_in;
   logic [DATA_W-1:0]     hit_count_ff, hit_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  emit_ff, emit_in;
   logic [DATA_W-1:0]     dropped_ff, dropped_in;
   logic [SLOT_OUT_W-1:0] slot_ff, slot_in;
   logic                  evicted_ff, evicted_in;

   logic [DATA_W-1:0]     age;
   logic                  in_window;
   logic [DATA_W-1:0]     count_inc;

   // Compare unit: source and key of the entry under scan.
   assign stat.match    = (rd_entry.source == src_ff) && (rd_entry.key == key_ff);
   assign stat.out_busy = rsp_valid_ff && !rsp.ready;

   // Age against the window, with wrapping time, and the repeat count.
   assign age       = now_ff - hit_stamp_ff;
   assign in_window = age < window_ff;
   assign count_inc = hit_count_ff + DATA_W'(1);

   // Entry written back and the verdict of the event.
   always_comb begin
      wr_entry.source = src_ff;
      wr_entry.key    = key_ff;
      wr_entry.stamp  = now_ff;
      wr_entry.count  = '0;
      emit_in         = 1'b1;
      dropped_in      = '0;
      if (ctl.upd_hit) begin
         if (in_window) begin
            wr_entry.stamp = hit_stamp_ff;
            wr_entry.count = count_inc;
            emit_in        = 1'b0;
            dropped_in     = count_inc;
         end else begin
            dropped_in     = hit_count_ff;
         end
      end
      slot_in    = SLOT_OUT_W'(ctl.upd_slot);
      evicted_in = ctl.upd_evict;
   end

   // Captured request, hit entry and window register.
   always_comb begin
      window_in    = csr_wr_en ? csr_wr_data : window_ff;
      src_in       = ctl.load ? req_src_num : src_ff;
      key_in       = ctl.load ? (req_text_hash ^ (DATA_W'(req_src_num) << SOURCE_SHIFT))
                              : key_ff;
      now_in       = ctl.load ? req_now_ms : now_ff;
      hit_stamp_in = hit_stamp_ff;
      hit_count_in = hit_count_ff;
      if (ctl.cmp_vld && ctl.cmp_valid && stat.match) begin
         hit_stamp_in = rd_entry.stamp;
         hit_count_in = rd_entry.count;
      end
   end

   // The response register holds until its transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      key_ff       <= key_in;
      now_ff       <= now_in;
      hit_stamp_ff <= hit_stamp_in;
      hit_count_ff <= hit_count_in;
      if (ctl.update) begin
         emit_ff    <= emit_in;
         dropped_ff <= dropped_in;
         slot_ff    <= slot_in;
         evicted_ff <= evicted_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.emit          = emit_ff;
   assign rsp.dropped_count = dropped_ff;
   assign rsp.slot_used     = slot_ff;
   assign rsp.evicted       = evicted_ff;

endmodule

>>> design/alert_repeat_throttle.sv
// Channel  Dir  Fields
// req      in   src_num[2:0], text_hash[31:0], now_ms[31:0]
// rsp      out  emit, dropped_count[31:0], slot_used[3:0], evicted
// csr      in   wr_en, wr_data[31:0] (window_ms)
//
// Each event is accepted, then the slots are read in turn through the single read port
// of the slot memory and checked by the shared compare unit after the registered read,
// and the chosen slot is updated; a hit ends the scan early.
// Reset is synchronous, clears the valid bits and the handshakes, and loads WINDOW_RESET into the window.
// The next event is accepted while a verdict waits; the update stalls only when
// the previous verdict has still not been taken.
module alert_repeat_throttle import art_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [DATA_W-1:0] csr_wr_data,
   art_req_if.sink           req,
   art_rsp_if.source         rsp
);

   seq_ctl_type      ctl;
   dp_stat_type      stat;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   slot_entry_type   rd_entry;
   slot_entry_type   wr_entry;
   logic [ENTRY_W-1:0] rd_word;

   // Sequencer over the table scan.
   art_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .ctl       (ctl),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr)
   );

   // Slot table storage.
   art_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ctl.update),
      .wr_addr (ctl.upd_slot),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_entry = rd_word;

   // Compare, age and count logic with the response register.
   art_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_src_num   (req.src_num),
      .req_text_hash (req.text_hash),
      .req_now_ms    (req.now_ms),
      .ctl           (ctl),
      .stat          (stat),
      .rd_entry      (rd_entry),
      .wr_entry      (wr_entry),
      .rsp           (rsp)
   );

`ifndef SYNTHESIS
   // The table is only written while no new event can be taken.
   assert property (@(posedge clock) disable iff (reset) ctl.update |-> !req.ready)
      else $error("slot write while request port is ready");

   // A transfer on the request side starts a scan, so the port closes next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request port still ready after a transfer");

   // Every update presents a verdict in the next cycle.
   assert property (@(posedge clock) disable iff (reset) ctl.update |=> rsp.valid)
      else $error("update without a following response");

   // A suppressed event always comes from a hit, which never evicts.
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.emit) |-> !rsp.evicted)
      else $error("suppressed event reported as an eviction");
`endif

endmodule
